// ===== design/s20sx_pkg.sv =====
package s20sx_pkg;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam logic [2:0] CFG_KEY_A = 3'd0;
    localparam logic [2:0] CFG_KEY_B = 3'd1;
    localparam logic [2:0] CFG_KEY_C = 3'd2;
    localparam logic [2:0] CFG_KEY_D = 3'd3;
    localparam logic [2:0] CFG_NONCE = 3'd4;

    localparam logic [6:0] BLOCK_BYTES = 7'd64;

    // matrix positions of one quarter round
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
    } t_quad;

    function automatic t_quad quad_of(input logic [2:0] q);
        t_quad r;
        case (q)
            3'd0:    r = '{4'd0,  4'd4,  4'd8,  4'd12};
            3'd1:    r = '{4'd5,  4'd9,  4'd13, 4'd1};
            3'd2:    r = '{4'd10, 4'd14, 4'd2,  4'd6};
            3'd3:    r = '{4'd15, 4'd3,  4'd7,  4'd11};
            3'd4:    r = '{4'd0,  4'd1,  4'd2,  4'd3};
            3'd5:    r = '{4'd5,  4'd6,  4'd7,  4'd4};
            3'd6:    r = '{4'd10, 4'd11, 4'd8,  4'd9};
            default: r = '{4'd15, 4'd12, 4'd13, 4'd14};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // rotation for step 0..3 of a quarter round: 7, 9, 13, 18
    function automatic logic [31:0] rot_step(input logic [31:0] v, input logic [1:0] s);
        logic [31:0] r;
        case (s)
            2'd0:    r = {v[24:0], v[31:25]};
            2'd1:    r = {v[22:0], v[31:23]};
            2'd2:    r = {v[18:0], v[31:19]};
            default: r = {v[13:0], v[31:14]};
        endcase
        return r;
    endfunction

endpackage

// ===== design/salsa20_stream_xor.sv =====
// Salsa20/20 stream combiner: each message item is XORed with the next
// keystream byte.
// Input channel: i_in_valid / o_in_ready, payload i_msg_byte, i_first_byte.
// Output channel: o_out_valid / i_out_ready, payload o_out_byte.
// Config: i_cfg_we, i_cfg_idx, i_cfg_data; write only while idle.
// Flow: an item that stays in the current 64-byte block passes through
// S_READ (keystream word read) and S_OUT (result registered), then back to
// idle; no new item is taken before the last one is through. An item with
// first_byte set, or the item after 64 bytes, first runs the core: 16 input
// words loaded, 320 round steps (one read-modify-write of the working-matrix
// memory each), then feed-forward into the keystream block. The working
// matrix and keystream block sit in synchronous RAMs; the round step sets the rate.
// Reset: counter, byte position, key and nonce registers, step counters and handshake state cleared.
// Stall: the result holds in the output register; a new item is taken while idle
// once that register is free or being drained in the same cycle.
module salsa20_stream_xor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_RND, S_FF, S_READ, S_OUT
    } t_state;

    t_state      r_state;
    logic [63:0] r_key_a, r_key_b, r_key_c, r_key_d, r_nonce;
    logic [63:0] r_counter;
    logic [6:0]  r_pos;
    logic [7:0]  r_msg;
    logic [3:0]  r_idx;
    logic [1:0]  r_ph;
    logic [1:0]  r_s;
    logic [2:0]  r_q;
    logic [3:0]  r_dr;
    logic [31:0] r_t;
    logic        r_ov;
    logic [7:0]  r_out;

    // working matrix, two read ports and one write port
    logic [31:0] x_mem [16];
    logic [31:0] r_rd0, r_rd1;
    logic [3:0]  addr0, addr1, waddr;
    logic [31:0] wdata;
    logic        we;

    // keystream block
    logic [31:0] ks_mem [16];
    logic [31:0] r_ksword;
    logic        ks_we;
    logic [31:0] ks_wdata;

    logic [31:0] m_word;
    s20sx_pkg::t_quad quad;
    logic [3:0]  op0, op1, tgt;
    logic        accept;
    logic        last_step;
    logic [7:0]  ks_byte;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_ov || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_out;

    // input matrix word at r_idx
    always_comb begin
        case (r_idx)
            4'd0:    m_word = s20sx_pkg::SIGMA0;
            4'd1:    m_word = s20sx_pkg::swap32(r_key_a[31:0]);
            4'd2:    m_word = s20sx_pkg::swap32(r_key_a[63:32]);
            4'd3:    m_word = s20sx_pkg::swap32(r_key_b[31:0]);
            4'd4:    m_word = s20sx_pkg::swap32(r_key_b[63:32]);
            4'd5:    m_word = s20sx_pkg::SIGMA1;
            4'd6:    m_word = s20sx_pkg::swap32(r_nonce[63:32]);
            4'd7:    m_word = s20sx_pkg::swap32(r_nonce[31:0]);
            4'd8:    m_word = r_counter[31:0];
            4'd9:    m_word = r_counter[63:32];
            4'd10:   m_word = s20sx_pkg::SIGMA2;
            4'd11:   m_word = s20sx_pkg::swap32(r_key_c[31:0]);
            4'd12:   m_word = s20sx_pkg::swap32(r_key_c[63:32]);
            4'd13:   m_word = s20sx_pkg::swap32(r_key_d[31:0]);
            4'd14:   m_word = s20sx_pkg::swap32(r_key_d[63:32]);
            default: m_word = s20sx_pkg::SIGMA3;
        endcase
    end

    // operands and target of the current round step
    always_comb begin
        quad = s20sx_pkg::quad_of(r_q);
        case (r_s)
            2'd0:    begin op0 = quad.a; op1 = quad.d; tgt = quad.b; end
            2'd1:    begin op0 = quad.b; op1 = quad.a; tgt = quad.c; end
            2'd2:    begin op0 = quad.c; op1 = quad.b; tgt = quad.d; end
            default: begin op0 = quad.d; op1 = quad.c; tgt = quad.a; end
        endcase
    end

    // memory port control
    always_comb begin
        addr0    = r_idx;
        addr1    = op1;
        waddr    = r_idx;
        wdata    = m_word;
        we       = 1'b0;
        ks_we    = 1'b0;
        ks_wdata = r_rd0 + m_word;
        unique case (r_state)
            S_LOAD: we = 1'b1;
            S_RND: begin
                addr0 = (r_ph == 2'd0) ? op0 : tgt;
                waddr = tgt;
                wdata = r_rd0 ^ r_t;
                we    = (r_ph == 2'd2);
            end
            S_FF:    ks_we = (r_ph == 2'd1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            x_mem[waddr] <= wdata;
        end
        r_rd0 <= x_mem[addr0];
        r_rd1 <= x_mem[addr1];
    end

    always_ff @(posedge i_clk) begin
        if (ks_we) begin
            ks_mem[r_idx] <= ks_wdata;
        end
        r_ksword <= ks_mem[r_pos[5:2]];
    end

    assign last_step = (r_dr == 4'd9) && (r_q == 3'd7) && (r_s == 2'd3);

    always_comb begin
        case (r_pos[1:0])
            2'd0:    ks_byte = r_ksword[7:0];
            2'd1:    ks_byte = r_ksword[15:8];
            2'd2:    ks_byte = r_ksword[23:16];
            default: ks_byte = r_ksword[31:24];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_key_a   <= '0;
            r_key_b   <= '0;
            r_key_c   <= '0;
            r_key_d   <= '0;
            r_nonce   <= '0;
            r_counter <= '0;
            r_pos     <= '0;
            r_idx     <= '0;
            r_ph      <= '0;
            r_s       <= '0;
            r_q       <= '0;
            r_dr      <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    s20sx_pkg::CFG_KEY_A: r_key_a <= i_cfg_data;
                    s20sx_pkg::CFG_KEY_B: r_key_b <= i_cfg_data;
                    s20sx_pkg::CFG_KEY_C: r_key_c <= i_cfg_data;
                    s20sx_pkg::CFG_KEY_D: r_key_d <= i_cfg_data;
                    s20sx_pkg::CFG_NONCE: r_nonce <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_msg <= i_msg_byte;
                        r_idx <= '0;
                        if (i_first_byte) begin
                            r_counter <= '0;
                            r_pos     <= '0;
                            r_state   <= S_LOAD;
                        end else if (r_pos >= s20sx_pkg::BLOCK_BYTES) begin
                            r_counter <= r_counter + 64'd1;
                            r_pos     <= '0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_LOAD: begin
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd15) begin
                        r_ph    <= '0;
                        r_s     <= '0;
                        r_q     <= '0;
                        r_dr    <= '0;
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    // phase 0 reads operands, 1 reads target, 2 writes it back
                    if (r_ph == 2'd1) begin
                        r_t <= s20sx_pkg::rot_step(r_rd0 + r_rd1, r_s);
                    end
                    if (r_ph == 2'd2) begin
                        r_ph <= '0;
                        r_s  <= r_s + 2'd1;
                        if (r_s == 2'd3) begin
                            r_q <= r_q + 3'd1;
                            if (r_q == 3'd7) begin
                                r_dr <= r_dr + 4'd1;
                            end
                        end
                        if (last_step) begin
                            r_idx   <= '0;
                            r_state <= S_FF;
                        end
                    end else begin
                        r_ph <= r_ph + 2'd1;
                    end
                end
                S_FF: begin
                    if (r_ph == 2'd1) begin
                        r_ph  <= '0;
                        r_idx <= r_idx + 4'd1;
                        if (r_idx == 4'd15) begin
                            r_state <= S_READ;
                        end
                    end else begin
                        r_ph <= 2'd1;
                    end
                end
                S_READ: r_state <= S_OUT;
                S_OUT: begin
                    r_out   <= r_msg ^ ks_byte;
                    r_ov    <= 1'b1;
                    r_pos   <= r_pos + 7'd1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
